/* rtl/lfsa_pkg.sv */
// Package for the lowest free slot allocator.
// Holds field widths, parameter defaults, command and status codes.
// No dependencies.
package lfsa_pkg;

    // Parameter defaults
    localparam int SLOTS_DEF      = 64;
    localparam int IDS_DEF        = 256;
    localparam int COUNT_BITS_DEF = 16;

    // Transaction field widths
    localparam int CMD_W       = 1;
    localparam int ID_IN_W     = 8;
    localparam int SLOT_OUT_W  = 6;
    localparam int STATUS_W    = 3;
    localparam int USE_W       = 16;
    localparam int IN_FIELDS_W = CMD_W + ID_IN_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_PAD_W    = IN_TDATA_W - IN_FIELDS_W;
    localparam int OUT_FIELDS_W = SLOT_OUT_W + STATUS_W + USE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC    = 3'd0,
        ST_RELEASE  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOT_HELD = 3'd3,
        ST_HOLDS    = 3'd4
    } status_t;

endpackage

/* rtl/lfsa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/lowest_free_slot_allocator_top.sv */
// Lowest free slot allocator, top level.
// Depends on lfsa_pkg and lfsa_ram.
//
// Usage:
//   Slave stream carries requests: allocate a slot for an id, or release the
//   slot that id holds. Master stream carries one result per request: slot,
//   status and the slot's saturating allocation count.
//   Allocate picks the lowest-numbered free slot; errors (no free slot, id
//   already holds one, release without holding) return slot 0 and count 0.
// Throughput: one request per cycle while the output is not stalled. The rate is
//   set by the decision stage, which priority-encodes the free map and updates
//   the free map and held flags in the same cycle.
// Pipeline: request register with id-table read, decision stage with
//   use-count read, count update stage, output register.
// Reset: every slot free, no id holds a slot, all use counts zero. The
//   id-to-slot table is not cleared; its data is used only for ids that hold a slot.
// Stall: when the output register is full and m_axis_tready is low the whole
//   pipeline holds and s_axis_tready drops; otherwise s_axis_tready is high.
module lowest_free_slot_allocator_top
    import lfsa_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int IDS        = IDS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] cmd, [8:1] id, upper bits zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [5:0] slot, [8:6] status, [24:9] use_count, upper bits zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ID_W   = $clog2(IDS);

    // Id modulo IDS for every possible input id, packed ID_W bits per entry
    function automatic logic [(2**ID_IN_W)*ID_W-1:0] build_who_tab();
        logic [(2**ID_IN_W)*ID_W-1:0] tab;
        tab = '0;
        for (int v = 0; v < 2**ID_IN_W; v++)
        begin
            tab[v*ID_W +: ID_W] = ID_W'(v % IDS);
        end
        return tab;
    endfunction

    localparam logic [(2**ID_IN_W)*ID_W-1:0] WHO_TAB = build_who_tab();

    logic advance;
    logic accept;

    // Id reduction
    logic [ID_W-1:0] who;

    // Request stage
    logic              p1_vld_reg;
    cmd_t              p1_cmd_reg;
    logic [ID_W-1:0]   p1_who_reg;
    logic              p1_fwd_reg;
    logic              p1_fwd_next;
    logic [SLOT_W-1:0] p1_fwd_slot_reg;
    logic [SLOT_W-1:0] id_rdata;

    // Decision stage
    logic [SLOTS-1:0]  free_map_reg;
    logic [SLOTS-1:0]  free_map_next;
    logic [IDS-1:0]    holds_reg;
    logic [IDS-1:0]    holds_next;
    logic              free_any;
    logic [SLOT_W-1:0] low_idx;
    logic [SLOT_W-1:0] rel_slot;
    logic              held;
    status_t           res_status;
    logic [SLOT_W-1:0] res_slot;
    logic              res_ok;
    logic              res_alloc;
    logic              id_we;

    // Count stage
    logic                  p2_vld_reg;
    logic [SLOT_W-1:0]     p2_slot_reg;
    status_t               p2_status_reg;
    logic                  p2_ok_reg;
    logic                  p2_alloc_reg;
    logic                  p2_fwd_reg;
    logic                  p2_fwd_next;
    logic [COUNT_BITS-1:0] p2_fwd_cnt_reg;
    logic [COUNT_BITS-1:0] uses_rdata;
    logic [SLOTS-1:0]      uses_vld_reg;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_out;
    logic                  cnt_we;

    // Output register
    logic                  m_vld_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [USE_W-1:0]      m_count_reg;

    // Handshake: every stage moves together when the output can take a result
    assign advance       = !m_vld_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && advance;
    assign s_axis_tready = advance;

    // Reduce id modulo IDS by table lookup
    assign who = WHO_TAB[int'(s_axis_tdata[CMD_W +: ID_IN_W]) * ID_W +: ID_W];

    // Id-to-slot table, read on every advance, written by the decision stage
    lfsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (IDS)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (p1_who_reg),
        .wdata (low_idx),
        .re    (advance),
        .raddr (who),
        .rdata (id_rdata)
    );

    // Bypass a table write that lands in the same cycle as the read
    assign p1_fwd_next = id_we && (p1_who_reg == who);

    // Lowest free slot
    always_comb
    begin
        low_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_map_reg[i])
            begin
                low_idx = SLOT_W'(i);
            end
        end
    end
    assign free_any = |free_map_reg;
    assign held     = holds_reg[p1_who_reg];
    assign rel_slot = p1_fwd_reg ? p1_fwd_slot_reg : id_rdata;

    // Decision: status, slot and next free map / held flags
    always_comb
    begin
        res_status    = ST_ALLOC;
        res_slot      = '0;
        res_ok        = 1'b0;
        res_alloc     = 1'b0;
        free_map_next = free_map_reg;
        holds_next    = holds_reg;
        if (p1_vld_reg)
        begin
            case (p1_cmd_reg)
                CMD_ALLOC:
                begin
                    if (held)
                    begin
                        res_status = ST_HOLDS;
                    end
                    else if (!free_any)
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        res_status             = ST_ALLOC;
                        res_slot               = low_idx;
                        res_ok                 = 1'b1;
                        res_alloc              = 1'b1;
                        free_map_next[low_idx] = 1'b0;
                        holds_next[p1_who_reg] = 1'b1;
                    end
                end
                CMD_RELEASE:
                begin
                    if (!held)
                    begin
                        res_status = ST_NOT_HELD;
                    end
                    else
                    begin
                        res_status              = ST_RELEASE;
                        res_slot                = rel_slot;
                        res_ok                  = 1'b1;
                        free_map_next[rel_slot] = 1'b1;
                        holds_next[p1_who_reg]  = 1'b0;
                    end
                end
                default:
                begin
                    res_status = ST_ALLOC;
                end
            endcase
        end
    end
    assign id_we = advance && res_alloc;

    // Per-slot use counts, read by the decision stage, written by the count stage
    lfsa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOTS)
    ) u_uses_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (p2_slot_reg),
        .wdata (cnt_inc),
        .re    (advance),
        .raddr (res_slot),
        .rdata (uses_rdata)
    );

    // Count update, saturating; never-written entries read as zero
    always_comb
    begin
        if (p2_fwd_reg)
        begin
            cnt_cur = p2_fwd_cnt_reg;
        end
        else if (uses_vld_reg[p2_slot_reg])
        begin
            cnt_cur = uses_rdata;
        end
        else
        begin
            cnt_cur = '0;
        end
        cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
        if (!p2_ok_reg)
        begin
            cnt_out = '0;
        end
        else if (p2_alloc_reg)
        begin
            cnt_out = cnt_inc;
        end
        else
        begin
            cnt_out = cnt_cur;
        end
    end
    assign cnt_we      = advance && p2_vld_reg && p2_alloc_reg;
    assign p2_fwd_next = cnt_we && (p2_slot_reg == res_slot);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg   <= 1'b0;
            p1_fwd_reg   <= 1'b0;
            p2_vld_reg   <= 1'b0;
            p2_fwd_reg   <= 1'b0;
            m_vld_reg    <= 1'b0;
            free_map_reg <= '1;
            holds_reg    <= '0;
            uses_vld_reg <= '0;
        end
        else if (advance)
        begin
            p1_vld_reg   <= accept;
            p1_fwd_reg   <= p1_fwd_next;
            p2_vld_reg   <= p1_vld_reg;
            p2_fwd_reg   <= p2_fwd_next;
            m_vld_reg    <= p2_vld_reg;
            free_map_reg <= free_map_next;
            holds_reg    <= holds_next;
            if (cnt_we)
            begin
                uses_vld_reg[p2_slot_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_cmd_reg      <= cmd_t'(s_axis_tdata[CMD_W-1:0]);
            p1_who_reg      <= who;
            p1_fwd_slot_reg <= low_idx;
            p2_slot_reg     <= res_slot;
            p2_status_reg   <= res_status;
            p2_ok_reg       <= res_ok;
            p2_alloc_reg    <= res_alloc;
            p2_fwd_cnt_reg  <= cnt_inc;
            m_slot_reg      <= SLOT_OUT_W'(p2_slot_reg);
            m_status_reg    <= p2_status_reg;
            m_count_reg     <= USE_W'(cnt_out);
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_count_reg, m_status_reg, m_slot_reg};

endmodule

/* rtl/lfsa_checker.sv */
// Port-level checker for the lowest free slot allocator, with its bind.
// Depends on lfsa_pkg and lowest_free_slot_allocator_top.
module lfsa_checker
    import lfsa_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [SLOT_OUT_W-1:0] out_slot;
    logic [STATUS_W-1:0]   out_status;
    logic [USE_W-1:0]      out_count;

    assign out_slot   = m_axis_tdata[SLOT_OUT_W-1:0];
    assign out_status = m_axis_tdata[SLOT_OUT_W +: STATUS_W];
    assign out_count  = m_axis_tdata[SLOT_OUT_W + STATUS_W +: USE_W];

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An empty output register never blocks the input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // Error results carry slot 0 and count 0
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_status == ST_FULL || out_status == ST_NOT_HELD
                          || out_status == ST_HOLDS)
        |-> out_slot == '0 && out_count == '0)
        else $error("error result with nonzero slot or count");

    // A granted slot has been allocated at least once
    a_alloc_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_status == ST_ALLOC |-> out_count != '0)
        else $error("allocation with zero use count");

    // No result right after reset release
    a_rst_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind lowest_free_slot_allocator_top lfsa_checker u_lfsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
